// ===== rtl/ppi_pkg.sv =====
// Package for the particle pool integrator: item types, codes, sequencer states
// and the saturating fixed-point add. No dependencies.
package ppi_pkg;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] RPT_SPAWN    = 2'd0;
  localparam logic [1:0] RPT_PARTICLE = 2'd1;
  localparam logic [1:0] RPT_EMPTY    = 2'd2;

  localparam logic [2:0] CFG_GRAV_X  = 3'd0;
  localparam logic [2:0] CFG_GRAV_Y  = 3'd1;
  localparam logic [2:0] CFG_GRAV_Z  = 3'd2;
  localparam logic [2:0] CFG_TYPE_LO = 3'd3;
  localparam logic [2:0] CFG_TYPE_HI = 3'd4;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic               cmd;
    logic        [6:0]  spawn_count;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [15:0] particle_scale;
    logic        [1:0]  particle_kind;
    logic        [15:0] tick_step;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  report_kind;
    logic        [5:0]  slot;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic        [31:0] out_age;
    logic        [1:0]  out_kind;
    logic        [6:0]  live_count;
    logic        [6:0]  accepted;
    logic               last;
  } out_item_t;

  // one pool entry, axis 0..2 = x..z
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      age;
    logic [15:0]      scale;
    logic [1:0]       kind;
  } particle_t;

  typedef struct packed {
    logic [2:0] pos_we;
    logic [2:0] vel_we;
    logic       age_we;
    logic       scale_we;
    logic       kind_we;
  } store_we_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPAWN, ST_SP_OUT,
    ST_T_RD, ST_T_AGE, ST_T_CMP, ST_T_KF, ST_T_PM, ST_T_POS, ST_T_VEL,
    ST_T_MVRD, ST_T_MVWR, ST_T_END, ST_T_EMPTY,
    ST_D_RD, ST_D_OUT
  } state_t;

  // base + floor(prod / 256), saturated to signed 32 bits
  function automatic logic [31:0] sat_add(input logic signed [31:0] base,
                                          input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] shifted;
    logic signed [50:0]       sum;
    shifted = prod >>> 8;
    sum = 51'(base) + 51'(shifted);
    if (sum > 51'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (sum < -51'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return sum[31:0];
    end
  endfunction

endpackage

// ===== rtl/ppi_in_if.sv =====
// Input channel of the particle pool integrator: valid/ready plus one item.
// Depends on ppi_pkg.
interface ppi_in_if;
  logic             valid;
  logic             ready;
  ppi_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ppi_out_if.sv =====
// Result channel of the particle pool integrator: valid/ready plus one result.
// Depends on ppi_pkg.
interface ppi_out_if;
  logic               valid;
  logic               ready;
  ppi_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/ppi_store.sv =====
// Particle pool storage: per-field memories, one write and one read address,
// registered read data. Depends on ppi_pkg.
module ppi_store #(
  parameter int POOL_SIZE = 64,
  parameter int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [SW-1:0]       rd_addr,
  output ppi_pkg::particle_t  rdata,
  input  ppi_pkg::store_we_t  we,
  input  logic [SW-1:0]       wr_addr,
  input  ppi_pkg::particle_t  wdata
);

  logic [31:0] age_mem   [POOL_SIZE];
  logic [15:0] scale_mem [POOL_SIZE];
  logic [1:0]  kind_mem  [POOL_SIZE];
  // one position bank and one velocity bank per axis
  logic [31:0] pos_mem   [3][POOL_SIZE];
  logic [31:0] vel_mem   [3][POOL_SIZE];

  // write the enabled fields, register the read of every field
  always_ff @(posedge clk) begin
    if (we.age_we) begin
      age_mem[wr_addr] <= wdata.age;
    end
    if (we.scale_we) begin
      scale_mem[wr_addr] <= wdata.scale;
    end
    if (we.kind_we) begin
      kind_mem[wr_addr] <= wdata.kind;
    end
    for (int a = 0; a < 3; a++) begin
      if (we.pos_we[a]) begin
        pos_mem[a][wr_addr] <= wdata.pos[a];
      end
      if (we.vel_we[a]) begin
        vel_mem[a][wr_addr] <= wdata.vel[a];
      end
    end
    if (rd_en) begin
      rdata.age   <= age_mem[rd_addr];
      rdata.scale <= scale_mem[rd_addr];
      rdata.kind  <= kind_mem[rd_addr];
      for (int a = 0; a < 3; a++) begin
        rdata.pos[a] <= pos_mem[a][rd_addr];
        rdata.vel[a] <= vel_mem[a][rd_addr];
      end
    end
  end

endmodule

// ===== rtl/ppi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on ppi_pkg for operand widths.
module ppi_mul (
  input  logic                                clk,
  input  logic signed [ppi_pkg::MUL_A_W-1:0]  opa,
  input  logic signed [ppi_pkg::MUL_B_W-1:0]  opb,
  output logic signed [ppi_pkg::PROD_W-1:0]   prod
);

  // register every product; the sequencer picks it up in the next state
  always_ff @(posedge clk) begin
    prod <= ppi_pkg::PROD_W'(opa) * ppi_pkg::PROD_W'(opb);
  end

endmodule

// ===== rtl/particle_pool_integrator.sv =====
// Particle pool integrator: a pool of POOL_SIZE particles with Euler update and
// swap-remove on expiry. Depends on ppi_pkg, ppi_in_if, ppi_out_if, ppi_store, ppi_mul.
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// A spawn writes each accepted copy in turn and gives one status beat.
// A tick reads, ages and compares each particle; an expired one is replaced
// by a move of the last entry (read, then write), a survivor is integrated
// axis by axis, and the survivors are then read back and reported one by one.
// The survivor cost is set by the single shared multiplier: lifetime*scale,
// step*gravity scale, and then step*velocity and factor*gravity for each of
// the three axes, each product registered. Results are buffered in the pool
// itself and replayed after the walk, since every beat carries the final
// live count.
module particle_pool_integrator #(
  parameter int POOL_SIZE  = 64,
  parameter int TYPE_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  ppi_in_if.sink            in_ch,
  ppi_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int SW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);

  ppi_pkg::state_t state, state_next;

  // configuration registers
  logic [31:0] grav_x, grav_y, grav_z;
  logic [63:0] type_lo, type_hi;

  logic [LW-1:0]        live;
  logic [LW-1:0]        idx;
  logic [1:0]           axis;
  logic [6:0]           rem;
  logic [6:0]           take;
  logic [15:0]          step;
  logic [31:0]          age_reg;
  logic signed [24:0]   kf;
  ppi_pkg::in_item_t    in_reg;
  logic                 out_valid;
  ppi_pkg::out_item_t   out_data;

  // store and multiplier hookup
  logic                 rd_en;
  logic [SW-1:0]        rd_addr;
  ppi_pkg::particle_t   rdata;
  ppi_pkg::store_we_t   we;
  logic [SW-1:0]        wr_addr;
  ppi_pkg::particle_t   wdata;
  logic signed [ppi_pkg::MUL_A_W-1:0] opa;
  logic signed [ppi_pkg::MUL_B_W-1:0] opb;
  logic signed [ppi_pkg::PROD_W-1:0]  prod;

  logic                 out_free;
  logic                 out_load;
  logic                 in_beat;
  logic [6:0]           room;
  logic [31:0]          te;
  logic [15:0]          life;
  logic signed [15:0]   gscale;
  logic [32:0]          age_sum;
  logic [31:0]          age_new;
  logic                 expire;
  logic [31:0]          grav_sel;
  logic [31:0]          pos_new;
  logic [31:0]          vel_new;

  ppi_store #(.POOL_SIZE(POOL_SIZE), .SW(SW)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rdata   (rdata),
    .we      (we),
    .wr_addr (wr_addr),
    .wdata   (wdata)
  );

  ppi_mul u_mul (
    .clk  (clk),
    .opa  (opa),
    .opb  (opb),
    .prod (prod)
  );

  assign out_free     = !out_valid || out_ch.ready;
  assign out_load     = out_free && (state == ppi_pkg::ST_SP_OUT ||
                                     state == ppi_pkg::ST_T_EMPTY ||
                                     state == ppi_pkg::ST_D_OUT);
  assign in_ch.ready  = (state == ppi_pkg::ST_IDLE);
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign room         = 7'(POOL_SIZE) - 7'(live);

  // type entry of the particle read last; kinds past the table read as zero
  always_comb begin
    te = rdata.kind[0] ? (rdata.kind[1] ? type_hi[63:32] : type_lo[63:32])
                       : (rdata.kind[1] ? type_hi[31:0]  : type_lo[31:0]);
    if ({30'b0, rdata.kind} >= 32'(TYPE_COUNT)) begin
      te = '0;
    end
  end
  assign life   = te[15:0];
  assign gscale = te[31:16];

  // saturating age update and expiry test against lifetime * scale
  assign age_sum = {1'b0, rdata.age} + {9'b0, step, 8'b0};
  assign age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
  assign expire  = age_reg >= prod[31:0];

  always_comb begin
    case (axis)
      2'd0:    grav_sel = grav_x;
      2'd1:    grav_sel = grav_y;
      default: grav_sel = grav_z;
    endcase
  end
  assign pos_new = ppi_pkg::sat_add(rdata.pos[axis], prod);
  assign vel_new = ppi_pkg::sat_add(rdata.vel[axis], prod);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppi_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_ch.data.cmd == ppi_pkg::CMD_SPAWN) begin
            state_next = ppi_pkg::ST_SPAWN;
          end else if (live != '0) begin
            state_next = ppi_pkg::ST_T_RD;
          end else begin
            state_next = ppi_pkg::ST_T_END;
          end
        end
      end
      ppi_pkg::ST_SPAWN:  if (rem == '0) state_next = ppi_pkg::ST_SP_OUT;
      ppi_pkg::ST_SP_OUT: if (out_free) state_next = ppi_pkg::ST_IDLE;
      ppi_pkg::ST_T_RD:   state_next = ppi_pkg::ST_T_AGE;
      ppi_pkg::ST_T_AGE:  state_next = ppi_pkg::ST_T_CMP;
      ppi_pkg::ST_T_CMP:  state_next = expire ? ppi_pkg::ST_T_MVRD : ppi_pkg::ST_T_KF;
      ppi_pkg::ST_T_KF:   state_next = ppi_pkg::ST_T_PM;
      ppi_pkg::ST_T_PM:   state_next = ppi_pkg::ST_T_POS;
      ppi_pkg::ST_T_POS:  state_next = ppi_pkg::ST_T_VEL;
      ppi_pkg::ST_T_VEL: begin
        if (axis != 2'd2) begin
          state_next = ppi_pkg::ST_T_PM;
        end else if (idx + 1'b1 < live) begin
          state_next = ppi_pkg::ST_T_RD;
        end else begin
          state_next = ppi_pkg::ST_T_END;
        end
      end
      ppi_pkg::ST_T_MVRD: state_next = ppi_pkg::ST_T_MVWR;
      ppi_pkg::ST_T_MVWR: begin
        state_next = (idx < live - 1'b1) ? ppi_pkg::ST_T_RD : ppi_pkg::ST_T_END;
      end
      ppi_pkg::ST_T_END: begin
        state_next = (live == '0) ? ppi_pkg::ST_T_EMPTY : ppi_pkg::ST_D_RD;
      end
      ppi_pkg::ST_T_EMPTY: if (out_free) state_next = ppi_pkg::ST_IDLE;
      ppi_pkg::ST_D_RD:    state_next = ppi_pkg::ST_D_OUT;
      ppi_pkg::ST_D_OUT: begin
        if (out_free) begin
          state_next = (idx + 1'b1 == live) ? ppi_pkg::ST_IDLE : ppi_pkg::ST_D_RD;
        end
      end
      default: state_next = ppi_pkg::ST_IDLE;
    endcase
  end

  // store and multiplier controls
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[SW-1:0];
    we      = '0;
    wr_addr = idx[SW-1:0];
    wdata   = rdata;
    opa     = '0;
    opb     = '0;
    case (state)
      ppi_pkg::ST_SPAWN: begin
        wr_addr     = live[SW-1:0];
        wdata.pos   = {in_reg.pos_z, in_reg.pos_y, in_reg.pos_x};
        wdata.vel   = {in_reg.vel_z, in_reg.vel_y, in_reg.vel_x};
        wdata.age   = '0;
        wdata.scale = in_reg.particle_scale;
        wdata.kind  = in_reg.particle_kind;
        if (rem != '0) begin
          we = '1;
        end
      end
      ppi_pkg::ST_T_RD, ppi_pkg::ST_D_RD: rd_en = 1'b1;
      ppi_pkg::ST_T_AGE: begin
        we.age_we = 1'b1;
        wdata.age = age_new;
        opa = ppi_pkg::MUL_A_W'({1'b0, life});
        opb = ppi_pkg::MUL_B_W'({1'b0, rdata.scale});
      end
      ppi_pkg::ST_T_CMP: begin
        opa = ppi_pkg::MUL_A_W'({1'b0, step});
        opb = ppi_pkg::MUL_B_W'(gscale);
      end
      ppi_pkg::ST_T_PM: begin
        opa = ppi_pkg::MUL_A_W'({1'b0, step});
        opb = ppi_pkg::MUL_B_W'(signed'(rdata.vel[axis]));
      end
      ppi_pkg::ST_T_POS: begin
        we.pos_we[axis]  = 1'b1;
        wdata.pos[axis]  = pos_new;
        opa = kf;
        opb = ppi_pkg::MUL_B_W'(signed'(grav_sel));
      end
      ppi_pkg::ST_T_VEL: begin
        we.vel_we[axis] = 1'b1;
        wdata.vel[axis] = vel_new;
      end
      ppi_pkg::ST_T_MVRD: begin
        rd_en   = 1'b1;
        rd_addr = SW'(live - 1'b1);
      end
      ppi_pkg::ST_T_MVWR: we = '1;
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_x  <= '0;
      grav_y  <= 32'hFFF6_3333;
      grav_z  <= '0;
      type_lo <= '0;
      type_hi <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppi_pkg::CFG_GRAV_X:  grav_x  <= cfg_data[31:0];
        ppi_pkg::CFG_GRAV_Y:  grav_y  <= cfg_data[31:0];
        ppi_pkg::CFG_GRAV_Z:  grav_z  <= cfg_data[31:0];
        ppi_pkg::CFG_TYPE_LO: type_lo <= cfg_data;
        ppi_pkg::CFG_TYPE_HI: type_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppi_pkg::ST_IDLE;
      live      <= '0;
      idx       <= '0;
      axis      <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // load a new result beat or drop the one just taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ppi_pkg::ST_IDLE: begin
          idx <= '0;
          if (in_beat) begin
            rem <= (in_ch.data.spawn_count < room) ? in_ch.data.spawn_count : room;
          end
        end
        ppi_pkg::ST_SPAWN: begin
          if (rem != '0) begin
            rem  <= rem - 1'b1;
            live <= live + 1'b1;
          end
        end
        ppi_pkg::ST_T_KF: axis <= '0;
        ppi_pkg::ST_T_VEL: begin
          if (axis != 2'd2) begin
            axis <= axis + 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ppi_pkg::ST_T_MVWR: live <= live - 1'b1;
        ppi_pkg::ST_T_END: idx <= '0;
        ppi_pkg::ST_D_OUT: begin
          if (out_free) begin
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_reg <= in_ch.data;
      step   <= in_ch.data.tick_step;
      take   <= (in_ch.data.spawn_count < room) ? in_ch.data.spawn_count : room;
    end
    if (state == ppi_pkg::ST_T_AGE) begin
      age_reg <= age_new;
    end
    if (state == ppi_pkg::ST_T_KF) begin
      kf <= 25'(prod >>> 8);
    end
    if (out_free) begin
      case (state)
        ppi_pkg::ST_SP_OUT: begin
          out_data <= '{report_kind: ppi_pkg::RPT_SPAWN, live_count: 7'(live),
                        accepted: take, last: 1'b1, default: '0};
        end
        ppi_pkg::ST_T_EMPTY: begin
          out_data <= '{report_kind: ppi_pkg::RPT_EMPTY, last: 1'b1, default: '0};
        end
        ppi_pkg::ST_D_OUT: begin
          out_data.report_kind <= ppi_pkg::RPT_PARTICLE;
          out_data.slot        <= 6'(idx);
          out_data.out_pos_x   <= rdata.pos[0];
          out_data.out_pos_y   <= rdata.pos[1];
          out_data.out_pos_z   <= rdata.pos[2];
          out_data.out_age     <= rdata.age;
          out_data.out_kind    <= rdata.kind;
          out_data.live_count  <= 7'(live);
          out_data.accepted    <= '0;
          out_data.last        <= (idx + 1'b1 == live);
        end
        default: ;
      endcase
    end
  end

  // the pool never holds more than its size
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= LW'(POOL_SIZE))
    else $error("live count beyond pool size");

  // the final particle beat reports the highest live slot
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.last && out_ch.data.report_kind == ppi_pkg::RPT_PARTICLE
    |-> 7'(out_ch.data.slot) + 7'd1 == out_ch.data.live_count)
    else $error("last particle beat slot does not match live count");

  // a spawn never adds more than the pool now holds
  a_spawn_take: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.report_kind == ppi_pkg::RPT_SPAWN
    |-> out_ch.data.accepted <= out_ch.data.live_count)
    else $error("spawn accepted more than live count");

endmodule

// ===== tb/particle_pool_integrator_tb.sv =====
// Self-checking testbench for particle_pool_integrator: spawns, ticks and register
// phases, with a built-in pool predictor. Depends on ppi_pkg, ppi_in_if, ppi_out_if.
module particle_pool_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 64;
  localparam int STALL_LIMIT = 8000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = ppi_pkg::CFG_GRAV_X;
  logic [63:0] cfg_data = '0;

  ppi_in_if  in_ch();
  ppi_out_if out_ch();

  particle_pool_integrator u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor copy of registers and pool
  logic signed [31:0] grav [3];
  logic [63:0]        kind_table_lo, kind_table_hi;
  logic signed [31:0] pool_pos [POOL][3];
  logic signed [31:0] pool_vel [POOL][3];
  logic [31:0]        pool_age [POOL];
  logic [15:0]        pool_scale [POOL];
  logic [1:0]         pool_kind [POOL];
  int                 pool_live;

  ppi_pkg::in_item_t  pending_beats [$];
  ppi_pkg::out_item_t expected_reports [$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;
  bit        in_took = 1'b0;
  int        in_gap = 0;
  int        out_stall = 0;

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] kind_entry(logic [1:0] k);
    logic [63:0] w;
    w = k[1] ? kind_table_hi : kind_table_lo;
    return k[0] ? w[63:32] : w[31:0];
  endfunction

  // apply one accepted beat to the pool and queue the reports it causes
  task automatic integrate_beat(ppi_pkg::in_item_t it);
    ppi_pkg::out_item_t r, batch [$];
    int         i, take, last_slot;
    logic [31:0] te;
    logic signed [15:0] gs;
    longint     age, thr, stepv, kf, p, v;
    r = '0;
    if (it.cmd == ppi_pkg::CMD_SPAWN) begin
      take = (it.spawn_count < POOL - pool_live) ? it.spawn_count : POOL - pool_live;
      for (i = 0; i < take; i++) begin
        pool_pos[pool_live] = '{it.pos_x, it.pos_y, it.pos_z};
        pool_vel[pool_live] = '{it.vel_x, it.vel_y, it.vel_z};
        pool_age[pool_live] = '0;
        pool_scale[pool_live] = it.particle_scale;
        pool_kind[pool_live] = it.particle_kind;
        pool_live++;
      end
      r.report_kind = ppi_pkg::RPT_SPAWN;
      r.live_count = 7'(pool_live);
      r.accepted = 7'(take);
      r.last = 1'b1;
      expected_reports.push_back(r);
      return;
    end
    stepv = longint'(it.tick_step);
    i = 0;
    while (i < pool_live) begin
      te = kind_entry(pool_kind[i]);
      gs = te[31:16];
      age = longint'(pool_age[i]) + (stepv << 8);
      if (age > 64'h0_FFFF_FFFF) age = 64'h0_FFFF_FFFF;
      pool_age[i] = age[31:0];
      thr = longint'(te[15:0]) * longint'(pool_scale[i]);
      if (age >= thr) begin
        // swap the last entry in and recheck this slot
        last_slot = pool_live - 1;
        pool_pos[i] = pool_pos[last_slot];
        pool_vel[i] = pool_vel[last_slot];
        pool_age[i] = pool_age[last_slot];
        pool_scale[i] = pool_scale[last_slot];
        pool_kind[i] = pool_kind[last_slot];
        pool_live--;
        continue;
      end
      kf = (stepv * longint'(gs)) >>> 8;
      for (int a = 0; a < 3; a++) begin
        p = longint'(pool_pos[i][a]);
        v = longint'(pool_vel[i][a]);
        pool_pos[i][a] = clip32(p + ((stepv * v) >>> 8));
        pool_vel[i][a] = clip32(v + ((kf * longint'(grav[a])) >>> 8));
      end
      r = '0;
      r.report_kind = ppi_pkg::RPT_PARTICLE;
      r.slot = 6'(i);
      r.out_pos_x = pool_pos[i][0];
      r.out_pos_y = pool_pos[i][1];
      r.out_pos_z = pool_pos[i][2];
      r.out_age = pool_age[i];
      r.out_kind = pool_kind[i];
      batch.push_back(r);
      i++;
    end
    if (batch.size() == 0) begin
      r = '0;
      r.report_kind = ppi_pkg::RPT_EMPTY;
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[j]) begin
      batch[j].live_count = 7'(pool_live);
      if (j == batch.size() - 1) batch[j].last = 1'b1;
      expected_reports.push_back(batch[j]);
    end
  endtask

  // drive input beats; hold an offered beat until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      in_ch.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pending_beats.size() > 0) begin
      in_ch.data <= pending_beats.pop_front();
      in_ch.valid <= 1'b1;
      if (!calm && $urandom_range(0, 6) == 0) in_gap <= $urandom_range(1, 14);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // stall the result side in bursts
  always @(negedge clk) begin
    if (calm || rst) begin
      out_ch.ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= $urandom_range(0, 13);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // predict on input beats, check result beats, watch for a hang
  always @(posedge clk) begin
    ppi_pkg::out_item_t want, got;
    in_took <= in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) integrate_beat(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_reports.pop_front();
        if (got.report_kind != want.report_kind || got.slot != want.slot ||
            got.out_pos_x != want.out_pos_x || got.out_pos_y != want.out_pos_y ||
            got.out_pos_z != want.out_pos_z || got.out_age != want.out_age ||
            got.out_kind != want.out_kind || got.live_count != want.live_count ||
            got.accepted != want.accepted || got.last != want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("particle_pool_integrator_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ppi_pkg::CFG_GRAV_X:  grav[0] = val[31:0];
      ppi_pkg::CFG_GRAV_Y:  grav[1] = val[31:0];
      ppi_pkg::CFG_GRAV_Z:  grav[2] = val[31:0];
      ppi_pkg::CFG_TYPE_LO: kind_table_lo = val;
      ppi_pkg::CFG_TYPE_HI: kind_table_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_ch.valid && expected_reports.size() == 0);
    wait (in_ch.ready);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] kind_word();
    logic [15:0] life, gsc;
    life = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0600));
    gsc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0200) - 16'h0100);
    return {gsc, life};
  endfunction

  function automatic ppi_pkg::in_item_t random_beat();
    ppi_pkg::in_item_t it;
    it = ppi_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) < 4) begin
      it.cmd = ppi_pkg::CMD_SPAWN;
      it.spawn_count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 64))
                                                    : 7'($urandom_range(0, 6));
      if ($urandom_range(0, 2) != 0) begin
        it.pos_x = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        it.vel_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        it.particle_scale = 16'($urandom_range(0, 16'h0300));
      end
    end else begin
      it.cmd = ppi_pkg::CMD_TICK;
      if ($urandom_range(0, 5) != 0) it.tick_step = 16'($urandom_range(0, 16'h0100));
    end
    return it;
  endfunction

  task automatic random_run(int n);
    repeat (n) pending_beats.push_back(random_beat());
  endtask

  initial begin
    ppi_pkg::in_item_t d;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    grav = '{32'sd0, -32'sd642253, 32'sd0};
    kind_table_lo = '0;
    kind_table_hi = '0;
    pool_live = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase one: fixed table, directed corners, then random traffic
    write_reg(ppi_pkg::CFG_GRAV_X, 64'(32'sd65536));
    write_reg(ppi_pkg::CFG_GRAV_Y, 64'(-32'sd642253));
    write_reg(ppi_pkg::CFG_GRAV_Z, 64'(-32'sd32768));
    write_reg(ppi_pkg::CFG_TYPE_LO, {16'hFF80, 16'h0100, 16'h0100, 16'h0400});
    write_reg(ppi_pkg::CFG_TYPE_HI, {16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF});
    d = '0;
    d.cmd = ppi_pkg::CMD_SPAWN;
    pending_beats.push_back(d);                         // zero count
    d.cmd = ppi_pkg::CMD_TICK;
    d.tick_step = 16'h0040;
    pending_beats.push_back(d);                         // empty pool tick
    d = '1;
    d.cmd = ppi_pkg::CMD_SPAWN;
    d.spawn_count = 7'd1;
    d.pos_x = 32'sh7FFF_FFFF; d.pos_y = 32'sh7FFF_FFFF; d.pos_z = 32'sh7FFF_FFFF;
    d.vel_x = 32'sh7FFF_FFFF; d.vel_y = 32'sh7FFF_FFFF; d.vel_z = 32'sh7FFF_FFFF;
    d.particle_kind = 2'd2;
    pending_beats.push_back(d);                         // max fields
    d = '0;
    d.spawn_count = 7'd3;
    d.pos_x = 32'sh8000_0000; d.pos_y = 32'sh8000_0000; d.pos_z = 32'sh8000_0000;
    d.vel_x = 32'sh8000_0000; d.vel_y = 32'sh8000_0000; d.vel_z = 32'sh8000_0000;
    d.particle_scale = 16'h0100;
    pending_beats.push_back(d);                         // min fields
    d = '0; d.cmd = ppi_pkg::CMD_TICK;
    pending_beats.push_back(d);                         // zero step
    d.tick_step = 16'hFFFF;
    pending_beats.push_back(d);                         // largest step
    d = '0;
    d.spawn_count = 7'd64; d.particle_kind = 2'd1; d.particle_scale = 16'h0800;
    d.vel_x = 32'sh0001_0000;
    pending_beats.push_back(d);                         // count above room
    d.spawn_count = 7'd5;
    pending_beats.push_back(d);                         // pool full
    d = '0; d.cmd = ppi_pkg::CMD_TICK; d.tick_step = 16'h0040;
    repeat (3) pending_beats.push_back(d);
    d = '0; d.spawn_count = 7'd2; d.particle_kind = 2'd3; d.particle_scale = 16'h0200;
    pending_beats.push_back(d);                         // zero lifetime kind
    d.particle_kind = 2'd0; d.particle_scale = 16'h0000;
    pending_beats.push_back(d);                         // zero scale
    d = '0; d.cmd = ppi_pkg::CMD_TICK; d.tick_step = 16'h0001;
    pending_beats.push_back(d);
    random_run(35);
    drain();

    // phase two: gravity at its extremes, random table
    write_reg(ppi_pkg::CFG_GRAV_X, 64'(32'sh7FFF_FFFF));
    write_reg(ppi_pkg::CFG_GRAV_Y, 64'(32'sh8000_0000));
    write_reg(ppi_pkg::CFG_GRAV_Z, 64'(32'sh7FFF_FFFF));
    write_reg(ppi_pkg::CFG_TYPE_LO, {kind_word(), kind_word()});
    write_reg(ppi_pkg::CFG_TYPE_HI, {kind_word(), kind_word()});
    random_run(35);
    drain();

    // phase three: random gravity and table, no idling
    write_reg(ppi_pkg::CFG_GRAV_X, 64'($urandom));
    write_reg(ppi_pkg::CFG_GRAV_Y, 64'($urandom));
    write_reg(ppi_pkg::CFG_GRAV_Z, 64'($urandom));
    write_reg(ppi_pkg::CFG_TYPE_LO, {kind_word(), kind_word()});
    write_reg(ppi_pkg::CFG_TYPE_HI, {kind_word(), kind_word()});
    calm = 1'b1;
    random_run(35);
    drain();

    if (mismatches == 0) begin
      $display("particle_pool_integrator_tb: done, clean");
    end else begin
      $display("particle_pool_integrator_tb: done, errors");
    end
    $finish;
  end

endmodule
